// ----- rtl/core/stbs_pkg.sv -----
// ============================================================================
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ============================================================================
package stbs_pkg;

    localparam int TL_W        = 11;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_OUT   = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_t;

    typedef struct packed {
        logic init_empty;
        logic hit;
        logic done;
    } status_t;

endpackage

// ----- rtl/core/sorted_table_binary_search_top.sv -----
// ============================================================================
// sorted_table_binary_search_top
// Binary search over a sorted table of signed 32-bit entries.
// ============================================================================
// Usage:
//   s_axis carries one item: tuser = op, tdata = entry_index, entry_value,
//   search_key. A write item (op 0) stores entry_value at entry_index and
//   gives no result; an index at or beyond TABLE_DEPTH is dropped.
//   A search item (op 1) probes the first table_length entries (at most TABLE_DEPTH) by halving
//   and gives one m_axis item with found in tdata bit 0.
//   cfg_wr_en/cfg_wr_data set table_length; write it only while idle.
// Timing:
//   write item: accepted while idle, ready again the next cycle.
//   search item: accepted while idle, then one probe per cycle (the table RAM
//   read port is read once a cycle), up to floor(log2(len)) + 1 probes,
//   then the result sits in an output register until m_axis takes it.
//   s_axis_tready is low from a search accept until the result is taken.
// Reset:
//   table_length clears to 0, the table contents are undefined until written.
// ============================================================================
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index, entry_value, search_key, zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found, zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [stbs_pkg::TL_W-1:0]         cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (LW > stbs_pkg::IDX_W) ? LW : stbs_pkg::IDX_W;

    stbs_pkg::state_t                  state_reg, state_next;
    logic                              found_reg, found_next;
    logic [stbs_pkg::TL_W-1:0]         tbl_len_reg;
    stbs_pkg::ctrl_t                   ctrl;
    stbs_pkg::status_t                 status;
    logic [stbs_pkg::IDX_W-1:0]        in_index;
    logic signed [stbs_pkg::VAL_W-1:0] in_value;
    logic signed [stbs_pkg::VAL_W-1:0] in_key;
    logic                              in_accept;
    logic                              wr_en;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [stbs_pkg::VAL_W-1:0] rd_data;

    assign in_index  = s_axis_tdata[9:0];
    assign in_value  = s_axis_tdata[41:10];
    assign in_key    = s_axis_tdata[73:42];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign wr_en = in_accept && (s_axis_tuser == stbs_pkg::OP_WRITE) &&
                   (IW'(in_index) < IW'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_len_reg <= '0;
        end else if (cfg_wr_en) begin
            tbl_len_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        state_next    = state_reg;
        found_next    = found_reg;
        ctrl          = '0;
        rd_en         = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            stbs_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == stbs_pkg::OP_SEARCH)) begin
                    ctrl.load = 1'b1;
                    if (status.init_empty) begin
                        found_next = 1'b0;
                        state_next = stbs_pkg::ST_OUT;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = stbs_pkg::ST_PROBE;
                    end
                end
            end
            stbs_pkg::ST_PROBE: begin
                ctrl.step = 1'b1;
                if (status.done) begin
                    found_next = status.hit;
                    state_next = stbs_pkg::ST_OUT;
                end else begin
                    rd_en = 1'b1;
                end
            end
            stbs_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
    end

    assign m_axis_tdata = {{(stbs_pkg::M_TDATA_W-1){1'b0}}, found_reg};

    stbs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_probe_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .table_length (tbl_len_reg),
        .key_in       (in_key),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .status       (status)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_empty_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_axis_tuser == stbs_pkg::OP_SEARCH) && (tbl_len_reg == '0))
        |=> (m_axis_tvalid && !m_axis_tdata[0]))
        else $error("empty table search did not give not found");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_axis_tuser == stbs_pkg::OP_WRITE))
        |=> (s_axis_tready && !m_axis_tvalid))
        else $error("write item produced a result");

endmodule

// ----- rtl/core/stbs_table_ram.sv -----
// ============================================================================
// stbs_table_ram
// Table storage: one write port, one read port with registered read data.
// ============================================================================
module stbs_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [stbs_pkg::VAL_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [stbs_pkg::VAL_W-1:0] rd_data
);

    logic signed [stbs_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/stbs_probe_dp.sv -----
// ============================================================================
// stbs_probe_dp
// Probe datapath: interval bounds, midpoint and the shared signed compare.
// ============================================================================
module stbs_probe_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  stbs_pkg::ctrl_t                   ctrl,
    input  logic [stbs_pkg::TL_W-1:0]         table_length,
    input  logic signed [stbs_pkg::VAL_W-1:0] key_in,
    input  logic signed [stbs_pkg::VAL_W-1:0] rd_data,
    output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
    output stbs_pkg::status_t                 status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (LW > stbs_pkg::TL_W) ? LW : stbs_pkg::TL_W;

    logic [LW-1:0]                     lo_reg, lo_next;
    logic [LW-1:0]                     hi_reg, hi_next;
    logic [LW-1:0]                     mid_reg, mid_next;
    logic signed [stbs_pkg::VAL_W-1:0] key_reg;
    logic [LW-1:0]                     len_sat;
    logic [LW-1:0]                     init_mid;
    logic [LW-1:0]                     mid_up;
    logic [LW-1:0]                     mid_dn;
    logic [LW-1:0]                     lo_b;
    logic                              eq;
    logic                              gt;
    logic                              empty_next;

    assign len_sat  = (CW'(table_length) > CW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                            : LW'(table_length);
    assign init_mid = (len_sat - LW'(1)) >> 1;

    // shared compare unit
    assign eq = (rd_data == key_reg);
    assign gt = (rd_data > key_reg);

    // both candidate midpoints, picked by the compare
    assign lo_b   = mid_reg + LW'(1);
    assign mid_dn = lo_reg + ((mid_reg - lo_reg - LW'(1)) >> 1);
    assign mid_up = lo_b + ((hi_reg - lo_b - LW'(1)) >> 1);

    always_comb begin
        if (gt) begin
            lo_next    = lo_reg;
            hi_next    = mid_reg;
            empty_next = (mid_reg == lo_reg);
        end else begin
            lo_next    = lo_b;
            hi_next    = hi_reg;
            empty_next = (lo_b >= hi_reg);
        end
        if (ctrl.load) begin
            mid_next = init_mid;
        end else if (gt) begin
            mid_next = mid_dn;
        end else begin
            mid_next = mid_up;
        end
    end

    assign rd_addr           = mid_next[AW-1:0];
    assign status.init_empty = (len_sat == '0);
    assign status.hit        = eq;
    assign status.done       = eq | empty_next;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            lo_reg  <= '0;
            hi_reg  <= len_sat;
            mid_reg <= mid_next;
            key_reg <= key_in;
        end else if (ctrl.step) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
    end

    a_mid_in_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("probe midpoint outside interval");

    a_hi_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step |-> (hi_reg <= LW'(TABLE_DEPTH)))
        else $error("interval bound beyond table depth");

endmodule

// ----- verif/sorted_table_binary_search_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker
// Watches the item, result and table length ports of the search block. It
// keeps its own copy of the table, predicts the found flag of every accepted
// search by halving over that copy, and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // entry_index, entry_value, search_key, zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found, zero pad
    input  logic [stbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [stbs_pkg::TL_W-1:0]         cfg_wr_data,
    output int                                pending,
    output int                                fail_count
);
    import stbs_pkg::*;

    typedef struct {
        logic               found;
        logic signed [31:0] key;
        int                 seq;
    } lookup_t;

    logic signed [VAL_W-1:0] table_copy [DEPTH];
    logic [TL_W-1:0]         table_len;
    lookup_t                 found_queue [$];
    lookup_t                 oldest;
    int                      mismatches;
    int                      searches;
    logic [IDX_W-1:0]        in_idx;
    logic signed [VAL_W-1:0] in_val;
    logic signed [VAL_W-1:0] in_key;

    initial begin
        pending    = 0;
        fail_count = 0;
        mismatches = 0;
        searches   = 0;
        table_len  = '0;
        foreach (table_copy[i]) table_copy[i] = '0;
    end

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    function automatic logic probe_table(logic signed [VAL_W-1:0] key);
        int  lo_i;
        int  hi_i;
        int  mid;
        logic hit;
        lo_i = 0;
        hi_i = int'(table_len);
        if (hi_i > DEPTH) hi_i = DEPTH;
        hi_i = hi_i - 1;
        hit = 1'b0;
        while (!hit && lo_i <= hi_i) begin
            mid = lo_i + (hi_i - lo_i) / 2;
            if (table_copy[mid] == key) hit = 1'b1;
            else if (table_copy[mid] > key) hi_i = mid - 1;
            else lo_i = mid + 1;
        end
        return hit;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            table_len = '0;
            found_queue.delete();
        end else begin
            if (cfg_wr_en) table_len = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                in_idx = s_axis_tdata[IDX_W-1:0];
                in_val = s_axis_tdata[IDX_W +: VAL_W];
                in_key = s_axis_tdata[IDX_W + VAL_W +: VAL_W];
                if (s_axis_tuser == OP_WRITE) begin
                    if (int'(in_idx) < DEPTH) table_copy[in_idx] = in_val;
                end else begin
                    found_queue.push_back('{probe_table(in_key), in_key, searches});
                    searches++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (found_queue.size() == 0) begin
                    report_mismatch($sformatf("result with no search waiting, found=%0b",
                                              m_axis_tdata[0]));
                end else begin
                    oldest = found_queue.pop_front();
                    if (m_axis_tdata[0] !== oldest.found)
                        report_mismatch($sformatf("search %0d key %0d len %0d: found %0b, want %0b",
                                                  oldest.seq, oldest.key, table_len,
                                                  m_axis_tdata[0], oldest.found));
                end
            end
        end
        pending    <= found_queue.size();
        fail_count <= mismatches;
    end

endmodule

// ----- verif/sorted_table_binary_search_top_test.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_test
// Drives write and search items into the sorted table search block with
// random gaps and result stalls. Directed searches cover the table ends, an
// empty table, an oversized length and an unsorted table; random phases then
// reload short ascending tables and search for present, neighboring and
// random keys. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search_top_test;
    import stbs_pkg::*;

    localparam int          DEPTH      = 1024;
    localparam int          RAND_ITEMS = 700;
    localparam int unsigned LIMIT      = 2000000;
    localparam longint      MAX32      = 64'sd2147483647;
    localparam longint      MIN32      = -64'sd2147483648;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = OP_WRITE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_wr_en     = 1'b0;
    logic [TL_W-1:0]        cfg_wr_data   = '0;

    int                     pending;
    int                     fail_count;
    int unsigned            cycle_count   = 0;
    int                     items_sent    = 0;
    int                     calm_left     = 0;
    int                     ready_hold    = 0;
    int                     ready_pick;
    logic signed [31:0]     table_mirror [DEPTH];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sorted_table_binary_search_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    sorted_table_binary_search_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60) begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 40);
            end else if (ready_pick < 95) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) calm_left = $urandom_range(10, 40);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [31:0] val,
                             logic signed [31:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W - IDX_W - 2 * VAL_W){1'b0}}, key, val, idx};
        do @(posedge aclk); while (!s_axis_tready);
        if (op == OP_WRITE) table_mirror[idx] = val;
        items_sent++;
    endtask

    task automatic write_entry(int idx, logic signed [31:0] val);
        send_item(OP_WRITE, IDX_W'(idx), val, $urandom);
    endtask

    task automatic search_for(logic signed [31:0] key);
        send_item(OP_SEARCH, IDX_W'($urandom), $urandom, key);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_table_length(logic [TL_W-1:0] len);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ascending fill of entries 0..n-1, narrow runs give duplicates
    task automatic load_ascending(int n, bit from_min);
        longint             cur;
        longint             step_max;
        logic signed [31:0] start_v;
        start_v = $urandom;
        cur = (from_min || $urandom_range(0, 3) == 0) ? MIN32 : longint'(start_v);
        step_max = (MAX32 - cur) / n;
        if (!from_min && $urandom_range(0, 1) == 1 && step_max > 2) step_max = 2;
        for (int i = 0; i < n; i++) begin
            write_entry(i, 32'(cur));
            cur += longint'($urandom_range(32'(step_max), 0));
        end
    endtask

    function automatic logic signed [31:0] pick_key(int eff);
        int r;
        int i;
        r = $urandom_range(0, 99);
        i = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        if (eff > 0 && r < 45) return table_mirror[i];
        if (eff > 0 && r < 52) return table_mirror[i] + 32'sd1;
        if (eff > 0 && r < 60) return table_mirror[i] - 32'sd1;
        if (r < 65) return KEY_MIN;
        if (r < 70) return KEY_MAX;
        return $urandom;
    endfunction

    task automatic run_phase();
        int              r;
        int              eff;
        logic [TL_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 16) len = 1;
        else if (r < 22) len = 2;
        else if (r < 28) len = TL_W'(DEPTH);
        else if (r < 34) len = TL_W'($urandom_range(DEPTH + 1, 2047));
        else if (r < 37) len = 2047;
        else len = TL_W'($urandom_range(3, 24));
        set_table_length(len);
        eff = (int'(len) > DEPTH) ? DEPTH : int'(len);
        if (eff > 0 && eff <= 64) load_ascending(eff, 1'b0);
        repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 24) == 0) write_entry($urandom_range(0, DEPTH - 1), $urandom);
            search_for(pick_key(eff));
        end
    endtask

    initial begin
        int base;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // length still zero from reset
        search_for(32'sd0);

        load_ascending(DEPTH, 1'b1);
        write_entry(0, KEY_MIN);
        write_entry(DEPTH - 1, KEY_MAX);

        set_table_length(TL_W'(DEPTH));
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        search_for(table_mirror[511]);
        search_for(table_mirror[512]);
        search_for(table_mirror[300] + 32'sd1);
        search_for(32'sd0);
        search_for(-32'sd1);

        set_table_length(2047);
        search_for(table_mirror[DEPTH - 1]);
        search_for(table_mirror[700]);

        set_table_length(1);
        search_for(table_mirror[0]);
        search_for(KEY_MAX);

        set_table_length(0);
        search_for(KEY_MIN);

        // out of order table
        write_entry(0, 32'sd50);
        write_entry(1, -32'sd7);
        write_entry(2, 32'sd90);
        write_entry(3, 32'sd3);
        set_table_length(4);
        search_for(32'sd50);
        search_for(-32'sd7);
        search_for(32'sd90);
        search_for(32'sd3);

        base = items_sent;
        while (items_sent - base < RAND_ITEMS) run_phase();

        wait_quiet();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
